// File: hdl/c2p_pkg.sv
// Shared types and constants of the cartesian-to-polar converter.
`timescale 1ns / 1ps
`default_nettype none

package c2p_pkg;

    localparam int DATA_WIDTH  = 16;
    localparam int STAGES      = 16;
    localparam int GUARD_BITS  = 16;
    localparam int PHASE_W     = 16;

    // CORDIC iterations actually run, square-root digits, and pipeline depth
    localparam int ITERS       = (STAGES < 32) ? STAGES : 32;
    localparam int ROOT_ITERS  = DATA_WIDTH;
    localparam int DEPTH       = (ITERS > ROOT_ITERS) ? ITERS : ROOT_ITERS;

    // Working widths: x/y carry guard bits plus CORDIC gain and sign,
    // the angle accumulator holds radians * 2^30 with room beyond +/- 3*pi/2.
    localparam int SQ_W        = 2 * DATA_WIDTH;
    localparam int XY_W        = DATA_WIDTH + GUARD_BITS + 3;
    localparam int Z_W         = 35;

    localparam logic signed [Z_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [Z_W-1:0] ROUND_HALF  = 35'sd65536;
    localparam int                    PHASE_SHIFT = 17;
    localparam logic signed [Z_W-1:0] PHASE_LIMIT = 35'sd25736;

    // atan(2^-i) * 2^30, truncated
    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
        32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
        32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
        32'd262143,    32'd131071,    32'd65535,     32'd32767,
        32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127,
        32'd63,        32'd31,        32'd15,        32'd7,
        32'd3,         32'd1,         32'd0,         32'd0
    };

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] re_part;
        logic signed [DATA_WIDTH-1:0] im_part;
    } t_request;

    typedef struct packed {
        logic        [DATA_WIDTH-1:0] magnitude;
        logic signed [PHASE_W-1:0]    phase;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/cartesian_to_polar.sv
// Pipelined cartesian-to-polar converter: exact rounded magnitude and CORDIC phase.
`timescale 1ns / 1ps
`default_nettype none

// A request (real and imaginary part) is taken at every rising edge where
// start is high; busy stays low because the pipeline never stalls, so one
// request per clock is sustained. Each request yields exactly one result,
// shown on o_result for a single cycle with o_result_valid high, in request
// order. The result passes the input, prepare and sum-of-squares registers,
// the iteration stages and the Finish 1 and Finish 2 registers, and is taken
// at the edge that ends the cycle in which it is shown. The CORDIC vectoring
// stages, one shift-add rotation per register stage, run side by side with a
// bit-per-stage restoring square root of re^2 + im^2; the longer sets the length.
// The receiver cannot hold results off; a result not taken in its cycle is
// gone. Magnitude is round(sqrt(re^2 + im^2)); phase is radians * 8192,
// rounded half up and clamped to +/- 25736. A request with zero real part
// returns +pi/2 for a positive imaginary part and -pi/2 otherwise (the zero
// vector included); a request with zero imaginary part returns 0 or +pi.
module cartesian_to_polar (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  c2p_pkg::t_request   i_request,
    output logic                o_result_valid,
    output c2p_pkg::t_result    o_result
);
    import c2p_pkg::*;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   special;
        logic [SQ_W-1:0]        rem;
        logic [SQ_W-1:0]        root;
    } t_stage;

    // The pipeline has no back pressure: never refuse a request.
    assign busy = 1'b0;

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic     r_in_vld;
    t_request r_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
        r_in <= i_request;
    end

    // ---------------------------------------------------------------
    // Prepare: squares, quadrant fold, starting angle, special cases
    // ---------------------------------------------------------------
    logic                   r_pr_vld;
    logic [SQ_W-1:0]        r_sq_re, r_sq_im;
    logic signed [XY_W-1:0] r_x0, r_y0;
    logic signed [Z_W-1:0]  r_z0;
    logic                   r_special0;

    logic [SQ_W-1:0]        n_sq_re, n_sq_im;
    logic signed [XY_W-1:0] n_x0, n_y0;
    logic signed [XY_W-1:0] re_ext, im_ext;
    logic signed [Z_W-1:0]  n_z0;
    logic                   n_special0;
    logic                   re_zero, im_zero, re_neg;

    always_comb begin
        n_sq_re = $unsigned(SQ_W'(r_in.re_part) * SQ_W'(r_in.re_part));
        n_sq_im = $unsigned(SQ_W'(r_in.im_part) * SQ_W'(r_in.im_part));

        re_ext  = XY_W'(r_in.re_part);
        im_ext  = XY_W'(r_in.im_part);
        re_zero = (r_in.re_part == '0);
        im_zero = (r_in.im_part == '0);
        re_neg  = r_in.re_part[DATA_WIDTH-1];

        // Fold the left half-plane onto the right one.
        n_x0 = (re_neg ? -re_ext : re_ext) <<< GUARD_BITS;
        n_y0 = (re_neg ? -im_ext : im_ext) <<< GUARD_BITS;

        n_special0 = re_zero || im_zero;
        priority if (re_zero) begin
            n_z0 = (!r_in.im_part[DATA_WIDTH-1] && !im_zero) ? HALF_PI_Q30 : -HALF_PI_Q30;
        end else if (im_zero) begin
            n_z0 = re_neg ? PI_Q30 : '0;
        end else if (re_neg) begin
            n_z0 = r_in.im_part[DATA_WIDTH-1] ? -PI_Q30 : PI_Q30;
        end else begin
            n_z0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pr_vld <= 1'b0;
        end else begin
            r_pr_vld <= r_in_vld;
        end
        r_sq_re    <= n_sq_re;
        r_sq_im    <= n_sq_im;
        r_x0       <= n_x0;
        r_y0       <= n_y0;
        r_z0       <= n_z0;
        r_special0 <= n_special0;
    end

    // ---------------------------------------------------------------
    // Stage 0 of the iteration chain: sum of squares
    // ---------------------------------------------------------------
    t_stage           r_stg [DEPTH+1];
    logic [DEPTH:0]   r_stg_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_vld[0] <= 1'b0;
        end else begin
            r_stg_vld[0] <= r_pr_vld;
        end
        r_stg[0].x       <= r_x0;
        r_stg[0].y       <= r_y0;
        r_stg[0].z       <= r_z0;
        r_stg[0].special <= r_special0;
        r_stg[0].rem     <= r_sq_re + r_sq_im;
        r_stg[0].root    <= '0;
    end

    // ---------------------------------------------------------------
    // Iteration chain: one CORDIC rotation and one root digit per stage
    // ---------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_iter
        logic signed [XY_W-1:0] n_x, n_y;
        logic signed [Z_W-1:0]  n_z;
        logic                   n_special;
        logic [SQ_W-1:0]        n_rem, n_root;

        if (g < ITERS) begin : g_cordic
            logic signed [XY_W-1:0] dx, dy;
            logic signed [Z_W-1:0]  da;

            always_comb begin
                dx = r_stg[g].y >>> g;
                dy = r_stg[g].x >>> g;
                da = $signed({{(Z_W-32){1'b0}}, ATAN_Q30[g]});
                n_special = r_stg[g].special;
                // Rotate toward the x axis; hold the angle for special cases.
                if (!r_stg[g].y[XY_W-1]) begin
                    n_x = r_stg[g].x + dx;
                    n_y = r_stg[g].y - dy;
                    n_z = r_stg[g].special ? r_stg[g].z : r_stg[g].z + da;
                end else begin
                    n_x = r_stg[g].x - dx;
                    n_y = r_stg[g].y + dy;
                    n_z = r_stg[g].special ? r_stg[g].z : r_stg[g].z - da;
                end
            end
        end else begin : g_cordic_pass
            always_comb begin
                n_x       = r_stg[g].x;
                n_y       = r_stg[g].y;
                n_z       = r_stg[g].z;
                n_special = r_stg[g].special;
            end
        end

        if (g < ROOT_ITERS) begin : g_root
            localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * g);
            logic [SQ_W:0] trial;

            always_comb begin
                trial = {1'b0, r_stg[g].root} + {1'b0, BIT};
                if ({1'b0, r_stg[g].rem} >= trial) begin
                    n_rem  = r_stg[g].rem - trial[SQ_W-1:0];
                    n_root = (r_stg[g].root >> 1) + BIT;
                end else begin
                    n_rem  = r_stg[g].rem;
                    n_root = r_stg[g].root >> 1;
                end
            end
        end else begin : g_root_pass
            always_comb begin
                n_rem  = r_stg[g].rem;
                n_root = r_stg[g].root;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stg_vld[g+1] <= 1'b0;
            end else begin
                r_stg_vld[g+1] <= r_stg_vld[g];
            end
            r_stg[g+1].x       <= n_x;
            r_stg[g+1].y       <= n_y;
            r_stg[g+1].z       <= n_z;
            r_stg[g+1].special <= n_special;
            r_stg[g+1].rem     <= n_rem;
            r_stg[g+1].root    <= n_root;
        end
    end

    // ---------------------------------------------------------------
    // Finish 1: round the root to nearest, add half an output LSB to the angle
    // ---------------------------------------------------------------
    logic                   r_f1_vld;
    logic [DATA_WIDTH-1:0]  r_f1_mag;
    logic signed [Z_W-1:0]  r_f1_ang;

    logic [DATA_WIDTH-1:0]  root_lo;
    logic [DATA_WIDTH-1:0]  n_f1_mag;

    always_comb begin
        root_lo  = r_stg[DEPTH].root[DATA_WIDTH-1:0];
        // Remainder above the root means the true value passes root + 1/2.
        n_f1_mag = (r_stg[DEPTH].rem > r_stg[DEPTH].root) ? root_lo + DATA_WIDTH'(1)
                                                          : root_lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
        end else begin
            r_f1_vld <= r_stg_vld[DEPTH];
        end
        r_f1_mag <= n_f1_mag;
        r_f1_ang <= r_stg[DEPTH].z + ROUND_HALF;
    end

    // ---------------------------------------------------------------
    // Finish 2: scale the angle to 2^-13 rad and clamp into the output register
    // ---------------------------------------------------------------
    logic signed [Z_W-1:0] ang_scaled;
    logic signed [Z_W-1:0] ang_clamped;
    t_result               n_result;

    always_comb begin
        ang_scaled = r_f1_ang >>> PHASE_SHIFT;
        priority if (ang_scaled > PHASE_LIMIT) begin
            ang_clamped = PHASE_LIMIT;
        end else if (ang_scaled < -PHASE_LIMIT) begin
            ang_clamped = -PHASE_LIMIT;
        end else begin
            ang_clamped = ang_scaled;
        end
        n_result.magnitude = r_f1_mag;
        n_result.phase     = ang_clamped[PHASE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= r_f1_vld;
        end
        o_result <= n_result;
    end

endmodule

`default_nettype wire

// File: bench/tb_cartesian_to_polar.sv
// Self-checking bench for the cartesian-to-polar converter: directed table, random sweep.
`timescale 1ns / 1ps

module tb_cartesian_to_polar;

    import c2p_pkg::*;

    localparam int     CLK_HALF     = 5;
    localparam int     RESET_CYCLES = 6;
    localparam int     RANDOM_ITEMS = 400;
    localparam int     MAX_GAP      = 16;
    localparam int     SETTLE       = 40;     // well past the converter pipeline length
    localparam int     STALL_LIMIT  = 2000;   // cycles without any handshake
    localparam int     CORDIC_STEPS = (STAGES < 32) ? STAGES : 32;
    localparam longint PI_RAD       = 64'sd3373259426;
    localparam longint HALF_PI_RAD  = 64'sd1686629713;
    localparam longint PHASE_MAX    = 64'sd25736;

    typedef struct {
        int re;
        int im;
        bit typed;   // expected result written in the row
        int mag;
        int ph;
    } stim_row_t;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_request i_request;
    logic     o_result_valid;
    t_result  o_result;

    t_result  pending_polar [$];
    int       fail_count;
    int       requests_sent;
    int       results_checked;
    int       stall_cycles;
    bit       no_idle;

    stim_row_t directed_rows [23];

    cartesian_to_polar i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_request      (i_request),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // atan(2^-i) in radians * 2^30, truncated
    function automatic longint atan_q30(int i);
        case (i)
            0:  return 843314856;   1:  return 497837829;
            2:  return 263043836;   3:  return 133525158;
            4:  return 67021686;    5:  return 33543515;
            6:  return 16775850;    7:  return 8388437;
            8:  return 4194282;     9:  return 2097149;
            10: return 1048575;     11: return 524287;
            12: return 262143;      13: return 131071;
            14: return 65535;       15: return 32767;
            16: return 16383;       17: return 8191;
            18: return 4095;        19: return 2047;
            20: return 1023;        21: return 511;
            22: return 255;         23: return 127;
            24: return 63;          25: return 31;
            26: return 15;          27: return 7;
            28: return 3;           29: return 1;
            default: return 0;
        endcase
    endfunction

    // Exact rounded magnitude and CORDIC phase of one request.
    function automatic t_result polar_of(t_request rq);
        longint  re, im, sum, root, cand, x, y, z, off, dx, dy, t, p;
        t_result r;
        re   = longint'(rq.re_part);
        im   = longint'(rq.im_part);
        sum  = re * re + im * im;
        root = 0;
        for (int b = DATA_WIDTH; b >= 0; b--) begin
            cand = root + (64'sd1 << b);
            if (cand * cand <= sum) root = cand;
        end
        // round to nearest: sum exceeds (root + 1/2)^2 exactly when this holds
        if (sum - root * root > root) root++;

        if (re == 0) begin
            t = (im > 0) ? HALF_PI_RAD : -HALF_PI_RAD;
        end else if (im == 0) begin
            t = (re > 0) ? 64'sd0 : PI_RAD;
        end else begin
            x   = re;
            y   = im;
            off = 0;
            // fold the left half-plane onto the right, then add back +/- pi
            if (re < 0) begin
                x   = -re;
                y   = -im;
                off = (im >= 0) ? PI_RAD : -PI_RAD;
            end
            x = x * 65536;
            y = y * 65536;
            z = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_q30(i);
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_q30(i);
                end
            end
            t = off + z;
        end

        p = (t + 64'sd65536) >>> 17;
        if (p > PHASE_MAX)  p = PHASE_MAX;
        if (p < -PHASE_MAX) p = -PHASE_MAX;
        r.magnitude = root[DATA_WIDTH-1:0];
        r.phase     = p[PHASE_W-1:0];
        return r;
    endfunction

    // Drive one request after a random gap (none while no_idle is set); return at the edge that takes it.
    task automatic issue_request(t_request rq, t_result expected);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_request <= rq;
        forever begin
            @(posedge i_clk);
            if (start && !busy) break;
        end
        pending_polar.push_back(expected);
        requests_sent++;
    endtask

    // Hold start low until every outstanding result is back.
    task automatic wait_for_drain();
        start <= 1'b0;
        while (pending_polar.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_request();
        t_request rq;
        int       pick;
        int       edge_vals [6];
        edge_vals = '{-32768, -32767, -1, 0, 1, 32767};
        pick = $urandom_range(0, 9);
        case (pick)
            3: begin
                rq.re_part = DATA_WIDTH'($urandom_range(0, 32) - 16);
                rq.im_part = DATA_WIDTH'($urandom_range(0, 32) - 16);
            end
            4: begin
                rq.re_part = '0;
                rq.im_part = DATA_WIDTH'($urandom);
            end
            5: begin
                rq.re_part = DATA_WIDTH'($urandom);
                rq.im_part = '0;
            end
            6: begin
                rq.re_part = DATA_WIDTH'($urandom_range(1, 32767));
                rq.im_part = $urandom_range(0, 1) ? rq.re_part : -rq.re_part;
                if ($urandom_range(0, 1)) rq.re_part = -rq.re_part;
            end
            7: begin
                rq.re_part = DATA_WIDTH'(edge_vals[$urandom_range(0, 5)]);
                rq.im_part = DATA_WIDTH'(edge_vals[$urandom_range(0, 5)]);
            end
            8: begin
                rq.re_part = DATA_WIDTH'($urandom);
                rq.im_part = DATA_WIDTH'($urandom_range(0, 4) - 2);
                if ($urandom_range(0, 1)) begin
                    rq.im_part = rq.re_part;
                    rq.re_part = DATA_WIDTH'($urandom_range(0, 4) - 2);
                end
            end
            default: begin
                rq.re_part = DATA_WIDTH'($urandom);
                rq.im_part = DATA_WIDTH'($urandom);
            end
        endcase
        issue_request(rq, polar_of(rq));
    endtask

    // Check every result against the oldest outstanding expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_result_valid) begin
            if (pending_polar.size() == 0) begin
                $error("unexpected result: magnitude %0d phase %0d",
                       o_result.magnitude, o_result.phase);
                fail_count++;
            end else begin
                want = pending_polar.pop_front();
                results_checked++;
                if (o_result.magnitude !== want.magnitude) begin
                    $error("magnitude: expected %0d, actual %0d",
                           want.magnitude, o_result.magnitude);
                    fail_count++;
                end
                if (o_result.phase !== want.phase) begin
                    $error("phase: expected %0d, actual %0d", want.phase, o_result.phase);
                    fail_count++;
                end
            end
        end
    end

    // Abort when neither side hands anything over for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[cartesian_to_polar] ERROR");
            $finish;
        end
    end

    initial begin
        t_request rq;
        t_result  known;

        fail_count      = 0;
        requests_sent   = 0;
        results_checked = 0;
        stall_cycles    = 0;
        no_idle         = 1'b0;
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_request <= '0;

        // axis points (extremes included) and the zero vector carry typed results; the rest is predicted
        directed_rows = '{
            '{0,      0,      1, 0,     -12868},
            '{0,      1,      1, 1,      12868},
            '{0,      -1,     1, 1,     -12868},
            '{0,      32767,  1, 32767,  12868},
            '{0,      -32768, 1, 32768, -12868},
            '{1,      0,      1, 1,      0},
            '{32767,  0,      1, 32767,  0},
            '{-1,     0,      1, 1,      25736},
            '{-32768, 0,      1, 32768,  25736},
            '{3,      4,      0, 0,      0},
            '{-3,     -4,     0, 0,      0},
            '{1,      1,      0, 0,      0},
            '{-1,     1,      0, 0,      0},
            '{-1,     -1,     0, 0,      0},
            '{1,      -1,     0, 0,      0},
            '{32767,  32767,  0, 0,      0},
            '{-32768, -32768, 0, 0,      0},
            '{-32768, 32767,  0, 0,      0},
            '{32767,  -32768, 0, 0,      0},
            '{-32768, -1,     0, 0,      0},
            '{-32768, 1,      0, 0,      0},
            '{21845,  -21846, 0, 0,      0},
            '{-21846, 21845,  0, 0,      0}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            rq.re_part = DATA_WIDTH'(directed_rows[k].re);
            rq.im_part = DATA_WIDTH'(directed_rows[k].im);
            if (directed_rows[k].typed) begin
                known.magnitude = DATA_WIDTH'(directed_rows[k].mag);
                known.phase     = PHASE_W'(directed_rows[k].ph);
            end else begin
                known = polar_of(rq);
            end
            issue_request(rq, known);
        end
        wait_for_drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // switch between back-to-back bursts and gapped traffic
            if (n % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_ITEMS / 2) wait_for_drain();
            random_request();
        end

        wait_for_drain();
        repeat (SETTLE) @(posedge i_clk);
        if (pending_polar.size() != 0) begin
            $error("%0d results never arrived", pending_polar.size());
            fail_count++;
        end

        $display("Checked %0d of %0d requests: axes, zero vector, corners, diagonals,",
                 results_checked, requests_sent);
        $display("near-axis and full-range random points, in bursts and with gaps.");
        if (fail_count == 0) begin
            $display("[cartesian_to_polar] OK");
        end else begin
            $display("[cartesian_to_polar] ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/c2p_pkg.sv
hdl/cartesian_to_polar.sv
bench/tb_cartesian_to_polar.sv
